FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent assertions in the core
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while reset is high
`define RRWS_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define RRWS_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/rrws_pkg.sv
// ---------------------------------------------------------------------------
// rrws_pkg
// widths, register indexes and helpers for the remainder work split core
// ---------------------------------------------------------------------------
package rrws_pkg;

   localparam int RRWS_MAX_PROCS   = 4096;
   localparam int RRWS_COUNT_WIDTH = 32;

   // fixed field widths
   localparam int PROC_COUNT_W = 13;
   localparam int OWN_RANK_W   = 12;
   localparam int OUT_W        = 32;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PROC_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_RANK   = CSR_IDX_W'(1);

   localparam logic OP_DISTRIBUTE = 1'b0;
   localparam logic OP_RESET      = 1'b1;

   function automatic int max_of(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // width of a processor count up to max_procs
   function automatic int proc_width(input int max_procs);
      return $clog2(max_procs + 1);
   endfunction

   // width of an offset or rank below max_procs
   function automatic int offset_width(input int max_procs);
      return (max_procs > 1) ? $clog2(max_procs) : 1;
   endfunction

endpackage

FILE: rtl/core/rrws_ifs.sv
// ---------------------------------------------------------------------------
// rrws channel interfaces
// request, response and register write channels with valid/ready
// ---------------------------------------------------------------------------
interface rrws_req_if import rrws_pkg::*; #(
   parameter int COUNT_WIDTH = RRWS_COUNT_WIDTH
) ();
   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [COUNT_WIDTH-1:0] total_elements;

   modport source (output valid, output operation, output total_elements, input ready);
   modport sink   (input valid, input operation, input total_elements, output ready);
endinterface

interface rrws_rsp_if import rrws_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] local_elements;

   modport source (output valid, output local_elements, input ready);
   modport sink   (input valid, input local_elements, output ready);
endinterface

interface rrws_csr_if import rrws_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/rrws_div.sv
// ---------------------------------------------------------------------------
// rrws_div
// bit-serial restoring divider: count / procs and offset mod procs together
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rrws_div import rrws_pkg::*; #(
   parameter int CNT_W = RRWS_COUNT_WIDTH,
   parameter int P_W   = proc_width(RRWS_MAX_PROCS),
   parameter int OFF_W = offset_width(RRWS_MAX_PROCS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] dividend,
   input  logic [P_W-1:0]   divisor,
   input  logic [OFF_W-1:0] offset,
   output logic             busy,
   output logic [CNT_W-1:0] quotient,
   output logic [P_W-1:0]   remainder,
   output logic [P_W-1:0]   off_remainder
);

   localparam int STEPS  = max_of(CNT_W, OFF_W);
   localparam int STEP_W = $clog2(STEPS + 1);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  quo_ff, quo_in;
   logic [P_W-1:0]    rem_ff, rem_in;
   logic [P_W-1:0]    orem_ff, orem_in;
   logic [OFF_W-1:0]  osh_ff, osh_in;
   logic [P_W-1:0]    div_ff, div_in;

   logic [P_W:0] q_trial, q_diff, o_trial, o_diff;
   logic         q_ge, o_ge, q_act, o_act;

   always_comb begin
      q_trial = {rem_ff, quo_ff[CNT_W-1]};
      q_diff  = q_trial - {1'b0, div_ff};
      q_ge    = (q_trial >= {1'b0, div_ff});
      o_trial = {orem_ff, osh_ff[OFF_W-1]};
      o_diff  = o_trial - {1'b0, div_ff};
      o_ge    = (o_trial >= {1'b0, div_ff});
      // both operands are msb-aligned to the last step
      q_act   = (step_ff != '0) && (step_ff <= STEP_W'(CNT_W));
      o_act   = (step_ff != '0) && (step_ff <= STEP_W'(OFF_W));

      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      orem_in = orem_ff;
      osh_in  = osh_ff;
      div_in  = div_ff;
      if (start) begin
         step_in = STEP_W'(STEPS);
         quo_in  = dividend;
         rem_in  = '0;
         orem_in = '0;
         osh_in  = offset;
         div_in  = divisor;
      end else begin
         if (step_ff != '0) begin
            step_in = step_ff - STEP_W'(1);
         end
         if (q_act) begin
            quo_in = (quo_ff << 1) | CNT_W'(q_ge);
            rem_in = q_ge ? q_diff[P_W-1:0] : q_trial[P_W-1:0];
         end
         if (o_act) begin
            osh_in  = osh_ff << 1;
            orem_in = o_ge ? o_diff[P_W-1:0] : o_trial[P_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      orem_ff <= orem_in;
      osh_ff  <= osh_in;
      div_ff  <= div_in;
   end

   assign busy          = (step_ff != '0);
   assign quotient      = quo_ff;
   assign remainder     = rem_ff;
   assign off_remainder = orem_ff;

   `RRWS_ASSERT_RST(a_rem_below_divisor, clock, reset, (step_ff != '0) |-> ((rem_ff < div_ff) && (orem_ff < div_ff)), "partial remainder not below divisor")

endmodule

FILE: rtl/core/rotating_remainder_work_split_unit.sv
// ---------------------------------------------------------------------------
// rotating_remainder_work_split_unit
// per-processor share of a work count with a rotating remainder window
// ---------------------------------------------------------------------------
// flow: a nonzero count passes through the one-bit-per-cycle divider (ST_DIV),
//   the window step (ST_WRAP) and ST_EMIT, which waits for a free response slot
// a new request is taken only in ST_IDLE, after the last response is registered;
//   a zero count goes straight to ST_EMIT, an offset reset stays idle and gives no response
// reset: synchronous, clears the offset, sets proc_count to 1 and own_rank to 0
`include "assert_macros.svh"

module rotating_remainder_work_split_unit import rrws_pkg::*; #(
   parameter int MAX_PROCS   = RRWS_MAX_PROCS
) (
   input logic       clock,
   input logic       reset,
   rrws_req_if.sink  req_bus,
   rrws_rsp_if.source rsp_bus,
   rrws_csr_if.sink  csr_bus
);

   // count width is the package default RRWS_COUNT_WIDTH
   localparam int COUNT_WIDTH = RRWS_COUNT_WIDTH;
   localparam int P_W   = proc_width(MAX_PROCS);
   localparam int OFF_W = offset_width(MAX_PROCS);
   localparam int CMP_W = max_of(PROC_COUNT_W, P_W);
   localparam int RK_W  = max_of(OWN_RANK_W, OFF_W);
   localparam int SUM_W = COUNT_WIDTH + 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_WRAP = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [PROC_COUNT_W-1:0]  proc_count_ff, proc_count_in;
   logic [OWN_RANK_W-1:0]    own_rank_ff, own_rank_in;
   logic [OFF_W-1:0]         offset_ff, offset_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]         rsp_data_ff, rsp_data_in;
   logic                     zero_ff, zero_in;
   logic [P_W-1:0]           p_ff, p_in;
   logic [OFF_W-1:0]         next_ff, next_in;
   logic                     hit_ff, hit_in;

   logic                     req_fire, csr_fire, slot_free, div_start, div_busy;
   logic [CMP_W-1:0]         pc_ext, p_eff;
   logic [COUNT_WIDTH-1:0]   quotient;
   logic [P_W-1:0]           rem, orem;
   logic [P_W:0]             wsum, wdiff;
   logic [P_W-1:0]           wnext;
   logic [RK_W-1:0]          rank_x, off_x, next_x;
   logic [SUM_W-1:0]         share_sum;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign div_start     = req_fire && (req_bus.operation == OP_DISTRIBUTE)
                          && (req_bus.total_elements != '0);

   // zero clamps to one, large values saturate to the supported maximum
   always_comb begin
      pc_ext = CMP_W'(proc_count_ff);
      if (pc_ext == '0) begin
         p_eff = CMP_W'(1);
      end else if (pc_ext > CMP_W'(MAX_PROCS)) begin
         p_eff = CMP_W'(MAX_PROCS);
      end else begin
         p_eff = pc_ext;
      end
   end

   rrws_div #(
      .CNT_W (COUNT_WIDTH),
      .P_W   (P_W),
      .OFF_W (OFF_W)
   ) u_div (
      .clock         (clock),
      .reset         (reset),
      .start         (div_start),
      .dividend      (req_bus.total_elements),
      .divisor       (p_eff[P_W-1:0]),
      .offset        (offset_ff),
      .busy          (div_busy),
      .quotient      (quotient),
      .remainder     (rem),
      .off_remainder (orem)
   );

   // new offset and window test
   always_comb begin
      wsum   = {1'b0, rem} + {1'b0, orem};
      wdiff  = wsum - {1'b0, p_ff};
      wnext  = (wsum >= {1'b0, p_ff}) ? wdiff[P_W-1:0] : wsum[P_W-1:0];
      rank_x = RK_W'(own_rank_ff);
      off_x  = RK_W'(offset_ff);
      next_x = RK_W'(wnext[OFF_W-1:0]);
      if (next_x > off_x) begin
         hit_in = (rank_x >= off_x) && (rank_x < next_x);
      end else if (next_x < off_x) begin
         hit_in = (rank_x >= off_x) || (rank_x < next_x);
      end else begin
         hit_in = 1'b0;
      end
      next_in   = wnext[OFF_W-1:0];
      share_sum = SUM_W'(quotient) + SUM_W'(hit_ff);
   end

   always_comb begin
      state_in      = state_ff;
      proc_count_in = proc_count_ff;
      own_rank_in   = own_rank_ff;
      offset_in     = offset_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      zero_in       = zero_ff;
      p_in          = p_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_fire) begin
         unique case (csr_bus.index)
            CSR_PROC_COUNT: proc_count_in = csr_bus.data[PROC_COUNT_W-1:0];
            CSR_OWN_RANK:   own_rank_in   = csr_bus.data[OWN_RANK_W-1:0];
            default:        ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.operation == OP_RESET) begin
                  offset_in = '0;
               end else if (req_bus.total_elements == '0) begin
                  zero_in  = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  zero_in  = 1'b0;
                  p_in     = p_eff[P_W-1:0];
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = zero_ff ? '0 : OUT_W'(share_sum);
               if (!zero_ff) begin
                  offset_in = next_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         proc_count_ff <= PROC_COUNT_W'(1);
         own_rank_ff   <= '0;
         offset_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         proc_count_ff <= proc_count_in;
         own_rank_ff   <= own_rank_in;
         offset_ff     <= offset_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      zero_ff     <= zero_in;
      p_ff        <= p_in;
      if (state_ff == ST_WRAP) begin
         next_ff <= next_in;
         hit_ff  <= hit_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.local_elements = rsp_data_ff;

   `RRWS_ASSERT_RST(a_wrap_after_div, clock, reset,
      (state_ff == ST_WRAP) |-> !div_busy,
      "window step entered while divider busy")
   `RRWS_ASSERT_RST(a_div_starts, clock, reset,
      div_start |=> (div_busy && (state_ff == ST_DIV)),
      "divider not running after distribute transaction")
   `RRWS_ASSERT_RST(a_offset_cleared, clock, reset,
      (req_fire && (req_bus.operation == OP_RESET)) |=> (offset_ff == '0),
      "offset not cleared by reset transaction")
   `RRWS_ASSERT_RST(a_next_in_range, clock, reset,
      ((state_ff == ST_EMIT) && !zero_ff) |-> (P_W'(next_ff) < p_ff),
      "new offset not below processor count")

endmodule

FILE: tb/tb_rotating_remainder_work_split_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rotating_remainder_work_split_unit
// self-checking bench for the rotating remainder work split core. a clocked
// driver feeds split requests from a queue, a software predictor computes the
// share and the rotating offset for each accepted request, and a monitor
// compares every response against the oldest predicted share. register
// settings change between phases while the core is idle.
// ---------------------------------------------------------------------------
module tb_rotating_remainder_work_split_unit;
   import rrws_pkg::*;

   localparam int          HALF_PERIOD  = 6;
   localparam int          RESET_CYCLES = 8;
   localparam int          DRAIN_CYCLES = 45;
   localparam int          IDLE_LIMIT   = 3000;
   localparam int          RAND_PHASES  = 8;
   localparam int          CHUNK_ITEMS  = 38;
   localparam int          MAX_REPORTS  = 10;

   typedef struct packed {
      logic                          op;
      logic [RRWS_COUNT_WIDTH-1:0]   count;
   } split_req_type;

   logic clock;
   logic reset;

   rrws_req_if req_bus ();
   rrws_rsp_if rsp_bus ();
   rrws_csr_if csr_bus ();

   rotating_remainder_work_split_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor state, mirrors the core's registers and offset
   logic [PROC_COUNT_W-1:0] pc_reg;
   logic [OWN_RANK_W-1:0]   rank_reg;
   logic [OWN_RANK_W-1:0]   rem_offset;

   split_req_type     split_req_q[$];
   logic [OUT_W-1:0]  share_q[$];

   int unsigned errors;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned quiet_cycles;
   bit          tx_gaps;
   bit          rx_stalls;

   split_req_type     cur_req;
   logic [OWN_RANK_W-1:0] nxt_off;
   logic [OUT_W-1:0]  want_share;

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   function automatic longint unsigned eff_procs(input logic [PROC_COUNT_W-1:0] pc);
      longint unsigned p;
      p = 64'(pc);
      if (p == 0) p = 64'(1);
      if (p > 64'(RRWS_MAX_PROCS)) p = 64'(RRWS_MAX_PROCS);
      return p;
   endfunction

   // share of this rank, plus the offset that follows the transaction
   function automatic logic [OUT_W-1:0] split_share(
      input  logic [RRWS_COUNT_WIDTH-1:0] count,
      input  logic [PROC_COUNT_W-1:0]     pc,
      input  logic [OWN_RANK_W-1:0]       rank,
      input  logic [OWN_RANK_W-1:0]       off,
      output logic [OWN_RANK_W-1:0]       next_off);
      longint unsigned p;
      longint unsigned share;
      longint unsigned nxt;
      longint unsigned o;
      longint unsigned r;
      p = eff_procs(pc);
      o = 64'(off);
      r = 64'(rank);
      next_off = off;
      if (count == 0) return '0;
      share = 64'(count) / p;
      nxt = ((o % p) + (64'(count) % p)) % p;
      if (nxt > o) begin
         if (r >= o && r < nxt) share += 1;
      end else if (nxt < o) begin
         // window wraps past the last processor
         if (r >= o || r < nxt) share += 1;
      end
      next_off = nxt[OWN_RANK_W-1:0];
      return share[OUT_W-1:0];
   endfunction

   function automatic int unsigned pause_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      else if (r < 92) return $urandom_range(4, 10);
      else return $urandom_range(20, 60);
   endfunction

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // request driver and predictor
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.operation == OP_RESET) begin
               rem_offset = '0;
            end else begin
               want_share = split_share(req_bus.total_elements, pc_reg, rank_reg,
                                        rem_offset, nxt_off);
               share_q.push_back(want_share);
               rem_offset = nxt_off;
            end
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               req_bus.valid <= 1'b0;
               gap_left--;
            end else if (split_req_q.size() > 0) begin
               cur_req = split_req_q.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.operation      <= cur_req.op;
               req_bus.total_elements <= cur_req.count;
               gap_left = (tx_gaps && $urandom_range(0, 2) == 0) ? pause_len() : 0;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (rx_stalls && $urandom_range(0, 5) == 0) stall_left = pause_len();
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (share_q.size() == 0) begin
            flag_error($sformatf("unexpected response local_elements=%0d",
                                 rsp_bus.local_elements));
         end else if (rsp_bus.local_elements !== share_q[0]) begin
            flag_error($sformatf("local_elements expected %0d actual %0d",
                                 share_q[0], rsp_bus.local_elements));
            void'(share_q.pop_front());
         end else begin
            void'(share_q.pop_front());
         end
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready) || reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb_rotating_remainder_work_split_unit: done, errors");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_PROC_COUNT: pc_reg = data[PROC_COUNT_W-1:0];
         CSR_OWN_RANK:   rank_reg = data[OWN_RANK_W-1:0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   // let every queued transaction and response finish, plus the core's latency
   task automatic wait_idle();
      while (split_req_q.size() != 0 || req_bus.valid || share_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_item(input logic op, input logic [RRWS_COUNT_WIDTH-1:0] count);
      split_req_type it;
      it.op    = op;
      it.count = count;
      split_req_q.push_back(it);
   endtask

   task automatic push_random_item();
      longint unsigned p;
      int unsigned     r;
      logic [RRWS_COUNT_WIDTH-1:0] count;
      p = eff_procs(pc_reg);
      r = $urandom_range(0, 99);
      if (r < 8) count = '0;
      else if (r < 14) count = '1;
      else if (r < 45) count = RRWS_COUNT_WIDTH'($urandom_range(1, 3 * int'(p)));
      else if (r < 60)
         count = RRWS_COUNT_WIDTH'(64'($urandom_range(0, 1000)) * p
                                   + 64'($urandom_range(0, 2)));
      else count = RRWS_COUNT_WIDTH'($urandom);
      push_item(($urandom_range(0, 99) < 6) ? OP_RESET : OP_DISTRIBUTE, count);
   endtask

   initial begin
      logic [PROC_COUNT_W-1:0] pc_val;
      logic [OWN_RANK_W-1:0]   rank_val;
      int unsigned             r;

      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.operation      = OP_DISTRIBUTE;
      req_bus.total_elements = '0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = CSR_PROC_COUNT;
      csr_bus.data           = '0;
      pc_reg     = PROC_COUNT_W'(1);
      rank_reg   = '0;
      rem_offset = '0;
      errors     = 0;
      quiet_cycles = 0;
      tx_gaps    = 1'b0;
      rx_stalls  = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // five processors, rank inside the range, upper data bits ignored
      write_csr(CSR_PROC_COUNT, 16'hE005);
      write_csr(CSR_OWN_RANK, 16'hF003);
      push_item(OP_DISTRIBUTE, 32'd0);
      push_item(OP_DISTRIBUTE, 32'd1);
      push_item(OP_DISTRIBUTE, 32'd3);
      push_item(OP_DISTRIBUTE, 32'hFFFF_FFFF);
      push_item(OP_DISTRIBUTE, 32'd7);
      push_item(OP_DISTRIBUTE, 32'd5);
      push_item(OP_RESET, 32'hFFFF_FFFF);
      push_item(OP_DISTRIBUTE, 32'd4);
      push_item(OP_DISTRIBUTE, 32'h8000_0000);
      wait_idle();

      // zero processor count behaves as one
      write_csr(CSR_PROC_COUNT, 16'h0000);
      write_csr(CSR_OWN_RANK, 16'h0000);
      push_item(OP_DISTRIBUTE, 32'hFFFF_FFFF);
      push_item(OP_DISTRIBUTE, 32'd1);
      wait_idle();

      // oversized processor count saturates, highest rank
      write_csr(CSR_PROC_COUNT, 16'hFFFF);
      write_csr(CSR_OWN_RANK, 16'hFFFF);
      push_item(OP_DISTRIBUTE, 32'hFFFF_FFFF);
      push_item(OP_DISTRIBUTE, 32'd4095);
      push_item(OP_DISTRIBUTE, 32'd2);
      push_item(OP_RESET, 32'd0);
      wait_idle();

      // push the offset high, then shrink the count so the offset goes stale
      write_csr(CSR_PROC_COUNT, 16'd4096);
      write_csr(CSR_OWN_RANK, 16'd10);
      push_item(OP_DISTRIBUTE, 32'd4000);
      wait_idle();
      write_csr(CSR_PROC_COUNT, 16'd7);
      write_csr(CSR_OWN_RANK, 16'd9);
      push_item(OP_DISTRIBUTE, 32'd3);
      push_item(OP_DISTRIBUTE, 32'd12);
      push_item(OP_DISTRIBUTE, 32'd0);
      wait_idle();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         r = $urandom_range(0, 99);
         if (r < 40) pc_val = PROC_COUNT_W'($urandom_range(1, 16));
         else if (r < 55) pc_val = PROC_COUNT_W'($urandom_range(17, 200));
         else if (r < 62) pc_val = '0;
         else if (r < 70) pc_val = PROC_COUNT_W'(RRWS_MAX_PROCS);
         else if (r < 76) pc_val = PROC_COUNT_W'(1);
         else if (r < 84) pc_val = PROC_COUNT_W'($urandom_range(RRWS_MAX_PROCS + 1, 8191));
         else pc_val = PROC_COUNT_W'($urandom_range(1, RRWS_MAX_PROCS - 1));
         if ($urandom_range(0, 4) != 0)
            rank_val = OWN_RANK_W'($urandom_range(0, int'(eff_procs(pc_val)) - 1));
         else
            rank_val = OWN_RANK_W'($urandom_range(0, 4095));
         write_csr(CSR_PROC_COUNT, {3'($urandom), pc_val});
         write_csr(CSR_OWN_RANK, {4'($urandom), rank_val});
         // unused index, must be ignored
         if ($urandom_range(0, 2) == 0)
            write_csr(CSR_IDX_W'($urandom_range(2, 255)), CSR_DATA_W'($urandom));
         for (int ck = 0; ck < 2; ck++) begin
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            repeat (CHUNK_ITEMS) push_random_item();
            wait_idle();
         end
      end

      if (errors == 0 && share_q.size() == 0) begin
         $display("tb_rotating_remainder_work_split_unit: done, clean");
      end else begin
         $display("tb_rotating_remainder_work_split_unit: done, errors");
      end
      $finish;
   end

endmodule
